@@ src/quicksort_sorter_top_defines.svh @@
// Assertion macros shared by the sorter checker.
`ifndef QUICKSORT_SORTER_TOP_DEFINES_SVH
`define QUICKSORT_SORTER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define QSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/qss_pkg.sv @@
// Shared types and constants for the insertion-chain sorter.
package qss_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } ctrl_t;

endpackage

@@ src/quicksort_sorter_top.sv @@
// Sorter top level: request handshakes, count and drain control, cell chain.
// Load: one request per cycle, each inserted into the chain in the cycle it is taken
// if the chain has room; a request that finds it full is dropped and sets truncated.
// Drain: starts the cycle after the last request; one result per cycle from cell 0
// while out_stall is low. Input is stalled while draining. Reset clears count, flag
// and state; the cell values need no reset as only occupied cells are compared.
module quicksort_sorter_top
    import qss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  value_t value,
    input  logic   last,
    output logic   out_valid,
    input  logic   out_stall,
    output value_t sorted_value,
    output logic   final_res,
    output logic   truncated
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic   state_reg, state_next;
    count_t count_reg, count_next;
    logic   ovf_reg, ovf_next;

    logic   in_acc, out_acc, room;
    ctrl_t  ctrl;

    value_t cell_value [MAX_ITEMS];
    logic   keep       [MAX_ITEMS];
    logic   occupied   [MAX_ITEMS];

    assign in_stall  = (state_reg == ST_DRAIN);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign room      = (count_reg < count_t'(MAX_ITEMS));

    assign ctrl = '{insert: in_acc && room, shift: out_acc};

    assign sorted_value = cell_value[0];
    assign final_res    = (count_reg == count_t'(1));
    assign truncated    = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - count_t'(1);
                    if (count_reg == count_t'(1))
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            value_t left_v, right_v;
            logic   left_k;

            assign occupied[i] = (count_t'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_v = value;
                assign left_k = 1'b1;
            end
            else
            begin : g_body
                assign left_v = cell_value[i-1];
                assign left_k = keep[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_tail
                assign right_v = '0;
            end
            else
            begin : g_inner
                assign right_v = cell_value[i+1];
            end

            qss_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .ins_value   (value),
                .left_value  (left_v),
                .left_keep   (left_k),
                .right_value (right_v),
                .cell_value  (cell_value[i]),
                .keep        (keep[i])
            );
        end
    endgenerate

endmodule

@@ src/qss_cell.sv @@
// One sorting cell: holds a value, makes room on insert, shifts down on drain.
module qss_cell
    import qss_pkg::*;
(
    input  logic   clk,
    input  ctrl_t  ctrl,
    input  logic   occupied,
    input  value_t ins_value,
    input  value_t left_value,
    input  logic   left_keep,
    input  value_t right_value,
    output value_t cell_value,
    output logic   keep
);

    value_t value_reg;
    value_t value_next;

    // ties stay put, so a new value lands after its equals
    assign keep       = occupied && !(value_reg > ins_value);
    assign cell_value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                value_next = left_keep ? ins_value : left_value;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ src/qss_checker.sv @@
// Port-level checks for the sorter, bound to the top level.
`include "quicksort_sorter_top_defines.svh"

module qss_checker
    import qss_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_stall,
    input value_t value,
    input logic   last,
    input logic   out_valid,
    input logic   out_stall,
    input value_t sorted_value,
    input logic   final_res,
    input logic   truncated
);

    // a stalled result holds
    `QSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sorted_value), "stalled result changed")

    // no request is taken while results are pending
    `QSS_ASSERT_NOW(a_no_load_in_drain, out_valid, in_stall, "input open during drain")

    // the run ends after its final result is taken
    `QSS_ASSERT_NEXT(a_run_ends, out_valid && !out_stall && final_res, !out_valid && !in_stall, "run did not end")

    // drop flag is constant while the results of one run drain
    `QSS_ASSERT_NEXT(a_trunc_steady, out_valid && !final_res, truncated == $past(truncated), "drop flag changed in run")

    // results come in non-decreasing order
    `QSS_ASSERT_NEXT(a_order, out_valid && !out_stall && !final_res, sorted_value >= $past(sorted_value), "result order broken")

endmodule

bind quicksort_sorter_top qss_checker u_qss_checker (.*);
